@@ src/jse_pkg.sv @@
// jse_pkg: shared types, constants and byte helpers of the json string escape unit
// no dependencies; imported by jse_front, jse_cmd_fifo, jse_back and the top level
package jse_pkg;

	localparam logic [7:0] ChNul    = 8'h00;
	localparam logic [7:0] ChBs     = 8'h08;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChFf     = 8'h0C;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChU      = 8'h75;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChHigh   = 8'h80;
	localparam logic [7:0] LeadMin2 = 8'hC2;
	localparam logic [7:0] LeadMin3 = 8'hE0;
	localparam logic [7:0] LeadMin4 = 8'hF0;
	localparam logic [7:0] LeadEnd  = 8'hF5;
	localparam logic [7:0] Repl0    = 8'hEF;
	localparam logic [7:0] Repl1    = 8'hBF;
	localparam logic [7:0] Repl2    = 8'hBD;

	localparam logic [20:0] CpMin3   = 21'h000800;
	localparam logic [20:0] SurLo    = 21'h00D800;
	localparam logic [20:0] SurHi    = 21'h00DFFF;
	localparam logic [20:0] CpMin4   = 21'h010000;
	localparam logic [20:0] CpMax    = 21'h10FFFF;

	localparam int unsigned CmdDepth = 4;
	localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
	localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

	// what the byte itself turns into once any held bytes are dealt with
	typedef enum logic [2:0] {
		FR_NONE,
		FR_CLOSE,
		FR_ESC,
		FR_UHEX,
		FR_LIT,
		FR_REPL
	} fresh_t;

	typedef enum logic [1:0] {
		PH_OPEN,
		PH_REPL,
		PH_PASS,
		PH_FRESH
	} phase_t;

	// one entry of the command queue: all output of one accepted request
	typedef struct packed {
		logic            open;
		logic [1:0]      nrepl;
		logic [2:0]      npass;
		logic [2:0][7:0] held;
		logic [7:0]      c;
		fresh_t          kind;
	} cmd_t;

	typedef struct packed {
		logic   found;
		phase_t ph;
	} seg_t;

	function automatic fresh_t classify(input logic [7:0] c);
		fresh_t k;
		case (c)
			ChNul: k = FR_CLOSE;
			ChQuote, ChBslash, ChLf, ChCr, ChTab, ChBs, ChFf: k = FR_ESC;
			default: begin
				if (c < ChSpace) k = FR_UHEX;
				else if (c < ChHigh) k = FR_LIT;
				else if (c < LeadMin2) k = FR_REPL;
				else if (c < LeadEnd) k = FR_NONE;
				else k = FR_REPL;
			end
		endcase
		return k;
	endfunction

	function automatic logic [7:0] esc_char(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			ChLf: r = 8'h6E;
			ChCr: r = 8'h72;
			ChTab: r = 8'h74;
			ChBs: r = 8'h62;
			ChFf: r = 8'h66;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) r = ChZero + {4'd0, n};
		else r = 8'h57 + {4'd0, n};
		return r;
	endfunction

	function automatic logic [2:0] fresh_len(input fresh_t k);
		logic [2:0] r;
		case (k)
			FR_CLOSE: r = 3'd1;
			FR_LIT: r = 3'd1;
			FR_ESC: r = 3'd2;
			FR_REPL: r = 3'd3;
			FR_UHEX: r = 3'd6;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// first non-empty segment of cmd that follows segment ph
	function automatic seg_t next_after(input cmd_t cmd, input phase_t ph);
		seg_t   s;
		logic   has_repl;
		logic   has_pass;
		logic   has_fresh;
		has_repl  = (cmd.nrepl != 2'd0);
		has_pass  = (cmd.npass != 3'd0);
		has_fresh = (cmd.kind != FR_NONE);
		s.found = 1'b0;
		s.ph    = PH_FRESH;
		case (ph)
			PH_OPEN: begin
				if (has_repl) begin
					s.found = 1'b1;
					s.ph    = PH_REPL;
				end else if (has_pass) begin
					s.found = 1'b1;
					s.ph    = PH_PASS;
				end else if (has_fresh) begin
					s.found = 1'b1;
					s.ph    = PH_FRESH;
				end
			end
			PH_REPL: begin
				if (has_pass) begin
					s.found = 1'b1;
					s.ph    = PH_PASS;
				end else if (has_fresh) begin
					s.found = 1'b1;
					s.ph    = PH_FRESH;
				end
			end
			PH_PASS: begin
				if (has_fresh) begin
					s.found = 1'b1;
					s.ph    = PH_FRESH;
				end
			end
			default: s.found = 1'b0;
		endcase
		return s;
	endfunction

endpackage

@@ src/jse_front.sv @@
// jse_front: accepts string bytes, tracks utf-8 sequence state, issues at most one command per byte
// depends on jse_pkg
module jse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	output logic          cmd_push,
	output jse_pkg::cmd_t cmd
);
	import jse_pkg::*;

	logic            opened_q;
	logic [1:0]      held_count_q;
	logic [2:0]      seq_len_q;
	logic [20:0]     code_acc_q;
	logic [2:0][7:0] held_q;

	logic [1:0]  n_held_count;
	logic [2:0]  n_seq_len;
	logic [20:0] n_code_acc;
	logic        wr_en;
	logic [1:0]  wr_idx;
	logic        do_fresh;
	logic        is_cont;
	logic [20:0] cp;
	logic        seq_ok;
	fresh_t      kind;

	assign is_cont = (data_byte[7:6] == 2'b10);
	assign cp      = {code_acc_q[14:0], data_byte[5:0]};
	assign kind    = classify(data_byte);

	always_comb begin
		seq_ok = 1'b1;
		if (seq_len_q == 3'd3 && (cp < CpMin3 || (cp >= SurLo && cp <= SurHi))) seq_ok = 1'b0;
		if (seq_len_q == 3'd4 && (cp < CpMin4 || cp > CpMax)) seq_ok = 1'b0;
	end

	always_comb begin
		cmd          = '0;
		cmd.open     = !opened_q;
		cmd.held     = held_q;
		cmd.c        = data_byte;
		cmd.kind     = FR_NONE;
		n_held_count = held_count_q;
		n_seq_len    = seq_len_q;
		n_code_acc   = code_acc_q;
		wr_en        = 1'b0;
		wr_idx       = held_count_q;
		do_fresh     = 1'b0;
		if (held_count_q != 2'd0 && is_cont) begin
			if (({1'b0, held_count_q} + 3'd1) >= seq_len_q) begin
				n_held_count = 2'd0;
				n_seq_len    = 3'd0;
				n_code_acc   = '0;
				if (seq_ok) begin
					cmd.npass = {1'b0, held_count_q} + 3'd1;
				end else begin
					cmd.nrepl = held_count_q;
					do_fresh  = 1'b1;
				end
			end else begin
				wr_en        = 1'b1;
				n_held_count = held_count_q + 2'd1;
				n_code_acc   = cp;
			end
		end else begin
			// a broken sequence flushes its held bytes before the byte is handled
			cmd.nrepl    = held_count_q;
			n_held_count = 2'd0;
			n_seq_len    = 3'd0;
			n_code_acc   = '0;
			do_fresh     = 1'b1;
		end
		if (do_fresh) begin
			cmd.kind = kind;
			if (data_byte >= LeadMin2 && data_byte < LeadEnd) begin
				wr_en        = 1'b1;
				wr_idx       = 2'd0;
				n_held_count = 2'd1;
				if (data_byte < LeadMin3) begin
					n_seq_len  = 3'd2;
					n_code_acc = {16'd0, data_byte[4:0]};
				end else if (data_byte < LeadMin4) begin
					n_seq_len  = 3'd3;
					n_code_acc = {17'd0, data_byte[3:0]};
				end else begin
					n_seq_len  = 3'd4;
					n_code_acc = {18'd0, data_byte[2:0]};
				end
			end
		end
	end

	assign cmd_push = accept && (cmd.open || cmd.nrepl != 2'd0 || cmd.npass != 3'd0
		|| cmd.kind != FR_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opened_q     <= 1'b0;
			held_count_q <= 2'd0;
			seq_len_q    <= 3'd0;
			code_acc_q   <= '0;
		end else if (accept) begin
			opened_q     <= (data_byte != ChNul);
			held_count_q <= n_held_count;
			seq_len_q    <= n_seq_len;
			code_acc_q   <= n_code_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[wr_idx] <= data_byte;
		end
	end

	a_held_open: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd0 |-> opened_q)
		else $error("bytes held outside an open string");

	a_held_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd0 |-> ({1'b0, held_count_q} < seq_len_q))
		else $error("held count reached sequence length");

	a_silent_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cmd_push |=> held_count_q != 2'd0)
		else $error("silent request left nothing held");

endmodule

@@ src/jse_cmd_fifo.sv @@
// jse_cmd_fifo: short command queue between front and back
// depends on jse_pkg (cmd_t, CmdDepth)
module jse_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  jse_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output jse_pkg::cmd_t rd_data
);
	import jse_pkg::*;

	cmd_t               mem_q [CmdDepth];
	logic [CmdPtrW-1:0] wr_ptr_q;
	logic [CmdPtrW-1:0] rd_ptr_q;
	logic [CmdCntW-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full     = (count_q == CmdCntW'(CmdDepth));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ src/jse_back.sv @@
// jse_back: expands queued cmds to escaped bytes, one per cycle while popped
// depends on jse_pkg (cmd_t, phase_t, byte helpers)
module jse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  jse_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          run_last
);
	import jse_pkg::*;

	phase_t     phase_q;
	logic [2:0] sub_q;
	logic [1:0] rep_q;
	logic       started_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	seg_t       first_seg;
	seg_t       after_seg;
	phase_t     cur_ph;
	logic [2:0] cur_sub;
	logic [1:0] cur_rep;
	phase_t     n_ph;
	logic [2:0] n_sub;
	logic [1:0] n_rep;
	logic       seg_end;
	logic       last;
	logic [7:0] byte_d;
	logic       advance;

	assign first_seg = cmd.open ? seg_t'{found: 1'b1, ph: PH_OPEN} : next_after(cmd, PH_OPEN);
	assign cur_ph    = started_q ? phase_q : first_seg.ph;
	assign cur_sub   = started_q ? sub_q : 3'd0;
	assign cur_rep   = started_q ? rep_q : 2'd0;
	assign after_seg = next_after(cmd, cur_ph);

	// next position within the command
	always_comb begin
		seg_end = 1'b0;
		n_ph    = cur_ph;
		n_sub   = cur_sub + 3'd1;
		n_rep   = cur_rep;
		case (cur_ph)
			PH_OPEN: seg_end = 1'b1;
			PH_REPL: begin
				if (cur_sub == 3'd2) begin
					n_sub = 3'd0;
					n_rep = cur_rep + 2'd1;
					seg_end = (cur_rep == cmd.nrepl - 2'd1);
				end
			end
			PH_PASS: seg_end = (cur_sub == cmd.npass - 3'd1);
			PH_FRESH: seg_end = (cur_sub == fresh_len(cmd.kind) - 3'd1);
			default: seg_end = 1'b1;
		endcase
		if (seg_end) begin
			n_ph  = after_seg.ph;
			n_sub = 3'd0;
			n_rep = 2'd0;
		end
		last = seg_end && !after_seg.found;
	end

	// byte at the current position
	always_comb begin
		byte_d = ChQuote;
		case (cur_ph)
			PH_OPEN: byte_d = ChQuote;
			PH_REPL: begin
				case (cur_sub)
					3'd0: byte_d = Repl0;
					3'd1: byte_d = Repl1;
					default: byte_d = Repl2;
				endcase
			end
			PH_PASS: byte_d = (cur_sub < cmd.npass - 3'd1) ? cmd.held[cur_sub[1:0]] : cmd.c;
			PH_FRESH: begin
				case (cmd.kind)
					FR_CLOSE: byte_d = ChQuote;
					FR_LIT: byte_d = cmd.c;
					FR_ESC: byte_d = (cur_sub == 3'd0) ? ChBslash : esc_char(cmd.c);
					FR_REPL: begin
						case (cur_sub)
							3'd0: byte_d = Repl0;
							3'd1: byte_d = Repl1;
							default: byte_d = Repl2;
						endcase
					end
					FR_UHEX: begin
						case (cur_sub)
							3'd0: byte_d = ChBslash;
							3'd1: byte_d = ChU;
							3'd2, 3'd3: byte_d = ChZero;
							3'd4: byte_d = hex_digit(cmd.c[7:4]);
							default: byte_d = hex_digit(cmd.c[3:0]);
						endcase
					end
					default: byte_d = ChQuote;
				endcase
			end
			default: byte_d = ChQuote;
		endcase
	end

	assign advance = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = advance && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			sub_q       <= 3'd0;
			rep_q       <= 2'd0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				started_q   <= !last;
				phase_q     <= n_ph;
				sub_q       <= n_sub;
				rep_q       <= n_rep;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			out_last_q <= last;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = out_last_q;

	a_start_next: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last |=> started_q)
		else $error("command dropped before its last byte");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> cmd_valid)
		else $error("command in progress left the queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_byte_q) && $stable(out_last_q))
		else $error("waiting output byte changed");

endmodule

@@ src/json_string_escape_utf8_sanitize_unit.sv @@
// json string escaper with utf-8 sanitizing: one string byte per request in, escaped bytes out
// path: a request is queued as a command, then its bytes leave via the output register
// throughput: one byte out per cycle while popped; a k-byte request holds the back until done,
// so plain text sustains one request per cycle and the 4-entry command queue absorbs expansions
// reset (arst_n low): string closed, nothing held, command queue and output register empty
// depends on jse_pkg, jse_front, jse_cmd_fifo, jse_back
module json_string_escape_utf8_sanitize_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import jse_pkg::*;

	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_valid;
	cmd_t cmd_head;
	logic cmd_pop;

	assign accept = push && !full;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	jse_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_in),
		.full     (full),
		.rd_en    (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_data  (cmd_head)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule
